/* src/expression_lexer_core_defines.svh */
// assertion macros for the expression lexer
`ifndef EXPRESSION_LEXER_CORE_DEFINES_SVH
`define EXPRESSION_LEXER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define EL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("expression lexer assertion failed");
`define EL_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("expression lexer assertion failed");
`else
`define EL_ASSERT(label, prop)
`define EL_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* src/el_pkg.sv */
package el_pkg;

  localparam int unsigned MAX_LINE_DEF = 1024;
  localparam int unsigned MAX_TOKS_DEF = 256;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned STAT_W  = 3;

  // at most three words come out of one character
  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT = 3'd0,
    KIND_INT   = 3'd1,
    KIND_REAL  = 3'd2,
    KIND_STR   = 3'd3,
    KIND_OP    = 3'd4,
    KIND_END   = 3'd5
  } tok_kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_STR_OPEN = 3'd1,
    ST_BAD_CHAR = 3'd2,
    ST_NO_EXP   = 3'd3,
    ST_INT_OVF  = 3'd4
  } tok_status_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   tok_len;
    logic [VAL_W-1:0]   int_value;
    logic [IDX_W-1:0]   token_index;
    tok_status_e        status;
    logic               last;
  } tok_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               room;
  } q_stat_t;

endpackage

/* src/el_if.sv */
interface el_char_if;
  import el_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            line_end;
  modport source (output valid, ch, line_end, input ready);
  modport sink (input valid, ch, line_end, output ready);
endinterface

interface el_tok_if;
  import el_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  tok_len;
  logic [VAL_W-1:0]  int_value;
  logic [IDX_W-1:0]  token_index;
  logic [STAT_W-1:0] status;
  logic              last;
  modport source (output valid, kind, start_pos, tok_len, int_value, token_index, status, last,
                  input ready);
  modport sink (input valid, kind, start_pos, tok_len, int_value, token_index, status, last,
                output ready);
endinterface

/* src/expression_lexer_core.sv */
// Expression lexer: takes one character of a command line per word on char_i and returns
// tokens on tok_o (kind, start, length, integer value, index in the line, status), with a
// zero-length end marker flagged last after each line. A character is taken in the cycle it
// is offered whenever the four-entry result queue has room for three words; its words can
// be taken from tok_o from the next cycle on, one per cycle. A line thus runs at one
// character per cycle while tok_o keeps up; a character that gives two or three words (it
// closes one token and emits another, or ends the line behind an open token) holds
// char_i.ready low until tok_o has drained the queue back to room for three words. After
// an error or the token limit the rest of the line is skipped; characters past the line
// limit are dropped.
`include "expression_lexer_core_defines.svh"

module expression_lexer_core #(
  parameter int unsigned MaxLine = el_pkg::MAX_LINE_DEF,
  parameter int unsigned MaxToks = el_pkg::MAX_TOKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  el_char_if.sink     char_i,
  el_tok_if.source    tok_o
);
  import el_pkg::*;

  tok_t [MAX_RES-1:0]     res;
  logic [RES_CNT_W-1:0]   wr_n;
  tok_t                   head;
  q_stat_t                q_stat;
  logic                   char_acc;
  logic                   head_valid;

  assign char_i.ready = q_stat.room;
  assign char_acc     = char_i.valid && char_i.ready;

  el_step #(
    .MaxLine (MaxLine),
    .MaxToks (MaxToks)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (char_acc),
    .ch_i       (char_i.ch),
    .line_end_i (char_i.line_end),
    .res_o      (res),
    .res_n_o    (wr_n)
  );

  el_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_n_i     (wr_n),
    .wr_data_i  (res),
    .rd_ready_i (tok_o.ready),
    .rd_valid_o (head_valid),
    .rd_data_o  (head),
    .stat_o     (q_stat)
  );

  assign tok_o.valid       = head_valid;
  assign tok_o.kind        = head.kind;
  assign tok_o.start_pos   = head.start_pos;
  assign tok_o.tok_len     = head.tok_len;
  assign tok_o.int_value   = head.int_value;
  assign tok_o.token_index = head.token_index;
  assign tok_o.status      = head.status;
  assign tok_o.last        = head.last;

  `EL_ASSERT(a_push_needs_accept, (wr_n != '0) |-> char_acc)
  `EL_ASSERT(a_line_end_marks, (char_acc && char_i.line_end) |-> (wr_n != '0))
  `EL_ASSERT(a_last_is_end, (tok_o.valid && tok_o.last) |-> (tok_o.kind == KIND_END))
  `EL_ASSERT(a_queue_bound, q_stat.count <= Q_CNT_W'(Q_DEPTH))

endmodule

/* src/el_step.sv */
module el_step #(
  parameter int unsigned MaxLine = el_pkg::MAX_LINE_DEF,
  parameter int unsigned MaxToks = el_pkg::MAX_TOKS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    acc_i,
  input  logic [el_pkg::CH_W-1:0]                 ch_i,
  input  logic                                    line_end_i,
  output el_pkg::tok_t [el_pkg::MAX_RES-1:0]      res_o,
  output logic [el_pkg::RES_CNT_W-1:0]            res_n_o
);
  import el_pkg::*;

  localparam int unsigned PosW = $clog2(MaxLine + 2);
  localparam int unsigned TokW = $clog2(MaxToks + 1);

  typedef enum logic [4:0] {
    PK_NONE  = 5'b00001,
    PK_IDENT = 5'b00010,
    PK_NUM   = 5'b00100,
    PK_STR   = 5'b01000,
    PK_OP    = 5'b10000
  } pend_e;

  typedef enum logic [4:0] {
    PH_INT   = 5'b00001,
    PH_FRAC  = 5'b00010,
    PH_EXP   = 5'b00100,
    PH_ESIGN = 5'b01000,
    PH_EDIG  = 5'b10000
  } phase_e;

  typedef struct packed {
    pend_e             pk;
    phase_e            ph;
    logic [CH_W-1:0]   fc;
    logic [PosW-1:0]   ts;
    logic [PosW-1:0]   tl;
    logic [VAL_W-1:0]  acc;
    logic              ovf;
    logic [PosW-1:0]   pos;
    logic [TokW-1:0]   ntok;
    logic              skip;
  } state_t;

  typedef struct packed {
    state_t                   s;
    tok_t [MAX_RES-1:0]       r;
    logic [RES_CNT_W-1:0]     n;
  } work_t;

  localparam state_t StReset = '{pk: PK_NONE, ph: PH_INT, fc: '0, ts: '0, tl: '0, acc: '0,
                                 ovf: 1'b0, pos: '0, ntok: '0, skip: 1'b0};

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == " ") || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic is_exp(input logic [CH_W-1:0] c);
    return (c == "e") || (c == "E");
  endfunction

  function automatic void put(inout work_t w, input tok_kind_e k, input logic [PosW-1:0] st,
                              input logic [PosW-1:0] ln, input logic [VAL_W-1:0] v,
                              input tok_status_e sts, input logic lst);
    if (w.n != RES_CNT_W'(MAX_RES)) begin
      w.r[w.n] = '{kind: k, start_pos: POS_W'(st), tok_len: POS_W'(ln), int_value: v,
                   token_index: IDX_W'(w.s.ntok), status: sts, last: lst};
      w.n = w.n + 1'b1;
    end
  endfunction

  function automatic void finish(inout work_t w, input tok_kind_e k,
                                 input logic [PosW-1:0] st, input logic [PosW-1:0] ln,
                                 input logic [VAL_W-1:0] v, input tok_status_e sts);
    put(w, k, st, ln, v, sts, 1'b0);
    w.s.ntok = w.s.ntok + 1'b1;
    w.s.pk = PK_NONE;
    // token limit reached: drop the rest of the line
    if (w.s.ntok >= TokW'(MaxToks)) begin
      w.s.skip = 1'b1;
      w.s.ts = st + ln;
    end
  endfunction

  function automatic void fail(inout work_t w, input tok_kind_e k,
                               input logic [PosW-1:0] st, input logic [PosW-1:0] ln,
                               input tok_status_e sts);
    put(w, k, st, ln, '0, sts, 1'b0);
    w.s.pk = PK_NONE;
    w.s.skip = 1'b1;
  endfunction

  function automatic void close_tok(inout work_t w);
    unique case (w.s.pk)
      PK_IDENT: finish(w, KIND_IDENT, w.s.ts, w.s.tl, '0, ST_OK);
      PK_NUM: begin
        if (w.s.ph == PH_INT) begin
          if (w.s.ovf) fail(w, KIND_INT, w.s.ts, w.s.tl, ST_INT_OVF);
          else finish(w, KIND_INT, w.s.ts, w.s.tl, w.s.acc, ST_OK);
        end else if ((w.s.ph == PH_EXP) || (w.s.ph == PH_ESIGN)) begin
          fail(w, KIND_REAL, w.s.ts + w.s.tl, '0, ST_NO_EXP);
        end else begin
          finish(w, KIND_REAL, w.s.ts, w.s.tl, '0, ST_OK);
        end
      end
      // string closed by the line end, the added quote counts
      PK_STR: finish(w, KIND_STR, w.s.ts, w.s.tl + 1'b1, '0, ST_STR_OPEN);
      PK_OP: finish(w, KIND_OP, w.s.ts, PosW'(1), '0, ST_OK);
      default: w.s.pk = PK_NONE;
    endcase
  endfunction

  function automatic void add_digit(inout work_t w, input logic [CH_W-1:0] c);
    logic [VAL_W+3:0] v;
    v = (VAL_W+4)'(w.s.acc) * 4'd10 + (VAL_W+4)'(c[3:0]);
    if (v > (VAL_W+4)'({VAL_W{1'b1}})) begin
      w.s.ovf = 1'b1;
      w.s.acc = '1;
    end else begin
      w.s.acc = v[VAL_W-1:0];
    end
  endfunction

  function automatic logic extend(inout work_t w, input logic [CH_W-1:0] c);
    logic ok;
    ok = 1'b0;
    unique case (w.s.pk)
      PK_IDENT: begin
        if (is_alpha(c) || is_digit(c) || (c == "_")) begin
          w.s.tl = w.s.tl + 1'b1;
          ok = 1'b1;
        end
      end
      PK_NUM: begin
        ok = 1'b1;
        unique case (w.s.ph)
          PH_INT: begin
            if (is_digit(c)) begin
              if (!w.s.ovf) add_digit(w, c);
            end else if (c == ".") begin
              w.s.ph = PH_FRAC;
            end else if (is_exp(c)) begin
              w.s.ph = PH_EXP;
            end else begin
              ok = 1'b0;
            end
          end
          PH_FRAC: begin
            if (is_exp(c)) w.s.ph = PH_EXP;
            else if (!is_digit(c)) ok = 1'b0;
          end
          PH_EXP: begin
            if (c == "-") w.s.ph = PH_ESIGN;
            else if (is_digit(c)) w.s.ph = PH_EDIG;
            else ok = 1'b0;
          end
          PH_ESIGN: begin
            if (is_digit(c)) w.s.ph = PH_EDIG;
            else ok = 1'b0;
          end
          default: begin
            if (!is_digit(c)) ok = 1'b0;
          end
        endcase
        if (ok) w.s.tl = w.s.tl + 1'b1;
      end
      PK_STR: begin
        ok = 1'b1;
        w.s.tl = w.s.tl + 1'b1;
        if (c == w.s.fc) finish(w, KIND_STR, w.s.ts, w.s.tl, '0, ST_OK);
      end
      PK_OP: begin
        if ((((w.s.fc == "&") || (w.s.fc == "|") || (w.s.fc == "=") || (w.s.fc == "*")) &&
             (c == w.s.fc)) ||
            (((w.s.fc == "!") || (w.s.fc == "<") || (w.s.fc == ">")) && (c == "="))) begin
          finish(w, KIND_OP, w.s.ts, PosW'(2), '0, ST_OK);
          ok = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic void start_new(inout work_t w, input logic [CH_W-1:0] c,
                                    input logic [PosW-1:0] p);
    w.s.ts = p;
    w.s.tl = PosW'(1);
    if (is_space(c)) begin
      w.s.pk = PK_NONE;
    end else if (is_alpha(c)) begin
      w.s.pk = PK_IDENT;
    end else if (is_digit(c) || (c == ".")) begin
      w.s.pk = PK_NUM;
      w.s.ovf = 1'b0;
      if (is_digit(c)) begin
        w.s.ph = PH_INT;
        w.s.acc = VAL_W'(c[3:0]);
      end else begin
        w.s.ph = PH_FRAC;
        w.s.acc = '0;
      end
    end else if ((c == "'") || (c == "\"")) begin
      w.s.pk = PK_STR;
      w.s.fc = c;
    end else begin
      unique case (c) inside
        "+", "-", "^", "/", "%", "~", "{", "}", "(", ")", "[", "]",
        ";", ":", "?", ",", "#", "$": finish(w, KIND_OP, p, PosW'(1), '0, ST_OK);
        "&", "|", "=", "*", "!", "<", ">": begin
          w.s.pk = PK_OP;
          w.s.fc = c;
        end
        default: fail(w, KIND_OP, p, PosW'(1), ST_BAD_CHAR);
      endcase
    end
  endfunction

  state_t          st_q;
  state_t          st_d;
  work_t           wk;
  logic            do_start;
  logic            ext_ok;
  logic [PosW-1:0] endpos;

  always_comb begin
    wk = '{s: st_q, r: '0, n: '0};
    do_start = 1'b0;
    ext_ok = 1'b0;
    endpos = '0;
    // characters past the line limit are dropped
    if (wk.s.pos < PosW'(MaxLine)) begin
      if (!wk.s.skip) begin
        if (wk.s.pk == PK_NONE) begin
          do_start = 1'b1;
        end else begin
          ext_ok = extend(wk, ch_i);
          if (!ext_ok) begin
            close_tok(wk);
            do_start = !wk.s.skip;
          end
        end
        if (do_start) start_new(wk, ch_i, wk.s.pos);
      end
      wk.s.pos = wk.s.pos + 1'b1;
    end
    if (line_end_i) begin
      endpos = wk.s.pos;
      if (!wk.s.skip && (wk.s.pk != PK_NONE)) begin
        if (wk.s.pk == PK_STR) endpos = wk.s.pos + 1'b1;
        close_tok(wk);
      end
      if (wk.s.ntok >= TokW'(MaxToks)) endpos = wk.s.ts;
      put(wk, KIND_END, endpos, '0, '0, ST_OK, 1'b1);
      wk.s = StReset;
    end
  end

  assign st_d    = wk.s;
  assign res_o   = wk.r;
  assign res_n_o = acc_i ? wk.n : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else if (acc_i) begin
      st_q <= st_d;
    end
  end

endmodule

/* src/el_queue.sv */
module el_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [el_pkg::RES_CNT_W-1:0]        wr_n_i,
  input  el_pkg::tok_t [el_pkg::MAX_RES-1:0]  wr_data_i,
  input  logic                                rd_ready_i,
  output logic                                rd_valid_o,
  output el_pkg::tok_t                        rd_data_o,
  output el_pkg::q_stat_t                     stat_o
);
  import el_pkg::*;

  localparam int unsigned QaW = $clog2(Q_DEPTH);

  tok_t               mem_q [Q_DEPTH];
  logic [QaW-1:0]     head_q, head_d;
  logic [QaW-1:0]     tail_q, tail_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               pop;

  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[head_q];
  assign pop        = rd_valid_o && rd_ready_i;

  assign head_d  = head_q + QaW'(pop);
  assign tail_d  = tail_q + QaW'(wr_n_i);
  assign count_d = count_q + Q_CNT_W'(wr_n_i) - Q_CNT_W'(pop);

  // room for the most words one character can produce
  assign stat_o.count = count_q;
  assign stat_o.room  = (count_q <= Q_CNT_W'(Q_DEPTH - MAX_RES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CNT_W'(i) < wr_n_i) mem_q[QaW'(tail_q + QaW'(i))] <= wr_data_i[i];
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import el_pkg::*;

  localparam int unsigned LINE_MAX = MAX_LINE_DEF;
  localparam int unsigned TOKS_MAX = MAX_TOKS_DEF;
  localparam int unsigned IDLE_PCT = 22;
  localparam int unsigned RAND_CHARS = 70;
  localparam int unsigned BURST_CHARS = 45;
  localparam longint WATCHDOG_NS = 5_000_000;

  typedef enum logic [2:0] {
    PEND_NONE, PEND_IDENT, PEND_NUM, PEND_STR, PEND_OP
  } pend_e;

  typedef enum logic [2:0] {
    NUM_INT, NUM_FRAC, NUM_EXP, NUM_EXP_SIGN, NUM_EXP_DIG
  } num_phase_e;

  logic clk_i;
  logic rst_ni;

  el_char_if char_if ();
  el_tok_if  tok_if ();

  expression_lexer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .tok_o  (tok_if)
  );

  always #10 clk_i = ~clk_i;

  // tokeniser state mirrored from the character stream
  pend_e       pend;
  num_phase_e  num_phase;
  logic [7:0]  open_ch;
  logic [10:0] tok_start;
  logic [10:0] tok_cnt;
  logic [31:0] acc;
  logic        ovf;
  logic [10:0] pos;
  logic [8:0]  n_toks;
  logic        skip;

  tok_t        expected_toks[$];
  logic [7:0]  line_buf[$];
  int          errors;
  bit          calm;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_line();
    pend      = PEND_NONE;
    num_phase = NUM_INT;
    open_ch   = '0;
    tok_start = '0;
    tok_cnt   = '0;
    acc       = '0;
    ovf       = 1'b0;
    pos       = '0;
    n_toks    = '0;
    skip      = 1'b0;
  endfunction

  function automatic void emit(tok_kind_e kind, logic [10:0] start, logic [10:0] len,
                               logic [30:0] val, tok_status_e st, logic last);
    tok_t t;
    t.kind        = kind;
    t.start_pos   = start;
    t.tok_len     = len;
    t.int_value   = val;
    t.token_index = n_toks;
    t.status      = st;
    t.last        = last;
    expected_toks.push_back(t);
  endfunction

  function automatic void finish_tok(tok_kind_e kind, logic [10:0] start, logic [10:0] len,
                                     logic [30:0] val, tok_status_e st);
    emit(kind, start, len, val, st, 1'b0);
    n_toks++;
    pend = PEND_NONE;
    if (n_toks >= TOKS_MAX) begin
      skip      = 1'b1;
      tok_start = start + len;
    end
  endfunction

  function automatic void abort_tok(tok_kind_e kind, logic [10:0] start, logic [10:0] len,
                                    tok_status_e st);
    emit(kind, start, len, '0, st, 1'b0);
    pend = PEND_NONE;
    skip = 1'b1;
  endfunction

  function automatic void close_pending();
    case (pend)
      PEND_IDENT: finish_tok(KIND_IDENT, tok_start, tok_cnt, '0, ST_OK);
      PEND_NUM: begin
        if (num_phase == NUM_INT) begin
          if (ovf) abort_tok(KIND_INT, tok_start, tok_cnt, ST_INT_OVF);
          else finish_tok(KIND_INT, tok_start, tok_cnt, acc[30:0], ST_OK);
        end else if (num_phase == NUM_EXP || num_phase == NUM_EXP_SIGN) begin
          abort_tok(KIND_REAL, tok_start + tok_cnt, '0, ST_NO_EXP);
        end else begin
          finish_tok(KIND_REAL, tok_start, tok_cnt, '0, ST_OK);
        end
      end
      PEND_STR: finish_tok(KIND_STR, tok_start, tok_cnt + 11'd1, '0, ST_STR_OPEN);
      PEND_OP: finish_tok(KIND_OP, tok_start, 11'd1, '0, ST_OK);
      default: pend = PEND_NONE;
    endcase
  endfunction

  function automatic void add_digit(logic [7:0] c);
    longint unsigned v;
    v = acc;
    v = v * 64'd10 + 64'(c - 8'h30);
    if (v > 64'h7FFF_FFFF) begin
      ovf = 1'b1;
      v   = 64'h7FFF_FFFF;
    end
    acc = v[31:0];
  endfunction

  // true when c belongs to, or completes, the token in progress
  function automatic bit grow_token(logic [7:0] c);
    bit is_e;
    is_e = (c == "e" || c == "E");
    case (pend)
      PEND_IDENT: begin
        if (!(is_alpha(c) || is_dig(c) || c == "_")) return 1'b0;
        tok_cnt++;
        return 1'b1;
      end
      PEND_NUM: begin
        case (num_phase)
          NUM_INT: begin
            if (is_dig(c)) begin
              if (!ovf) add_digit(c);
            end else if (c == ".") num_phase = NUM_FRAC;
            else if (is_e) num_phase = NUM_EXP;
            else return 1'b0;
          end
          NUM_FRAC: begin
            if (is_e) num_phase = NUM_EXP;
            else if (!is_dig(c)) return 1'b0;
          end
          NUM_EXP: begin
            if (c == "-") num_phase = NUM_EXP_SIGN;
            else if (is_dig(c)) num_phase = NUM_EXP_DIG;
            else return 1'b0;
          end
          NUM_EXP_SIGN: begin
            if (!is_dig(c)) return 1'b0;
            num_phase = NUM_EXP_DIG;
          end
          default: begin
            if (!is_dig(c)) return 1'b0;
          end
        endcase
        tok_cnt++;
        return 1'b1;
      end
      PEND_STR: begin
        tok_cnt++;
        if (c == open_ch) finish_tok(KIND_STR, tok_start, tok_cnt, '0, ST_OK);
        return 1'b1;
      end
      PEND_OP: begin
        if (((open_ch == "&" || open_ch == "|" || open_ch == "=" || open_ch == "*") &&
             c == open_ch) ||
            ((open_ch == "!" || open_ch == "<" || open_ch == ">") && c == "=")) begin
          finish_tok(KIND_OP, tok_start, 11'd2, '0, ST_OK);
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void start_token(logic [7:0] c, logic [10:0] p);
    tok_start = p;
    tok_cnt   = 11'd1;
    if (is_blank(c)) return;
    if (is_alpha(c)) begin
      pend = PEND_IDENT;
      return;
    end
    if (is_dig(c) || c == ".") begin
      pend      = PEND_NUM;
      ovf       = 1'b0;
      acc       = '0;
      num_phase = NUM_FRAC;
      if (is_dig(c)) begin
        num_phase = NUM_INT;
        acc       = 32'(c - 8'h30);
      end
      return;
    end
    if (c == "'" || c == "\"") begin
      pend    = PEND_STR;
      open_ch = c;
      return;
    end
    case (c)
      "+", "-", "^", "/", "%", "~", "{", "}", "(", ")", "[", "]",
      ";", ":", "?", ",", "#", "$":
        finish_tok(KIND_OP, p, 11'd1, '0, ST_OK);
      "&", "|", "=", "*", "!", "<", ">": begin
        pend    = PEND_OP;
        open_ch = c;
      end
      default: abort_tok(KIND_OP, p, 11'd1, ST_BAD_CHAR);
    endcase
  endfunction

  function automatic void lex_char(logic [7:0] c, logic eol);
    logic [10:0] end_at;
    if (pos < LINE_MAX) begin
      if (!skip) begin
        if (pend == PEND_NONE) begin
          start_token(c, pos);
        end else if (!grow_token(c)) begin
          close_pending();
          if (!skip) start_token(c, pos);
        end
      end
      pos++;
    end
    if (eol) begin
      end_at = pos;
      if (!skip && pend != PEND_NONE) begin
        // an unclosed string gets its quote added past the line
        if (pend == PEND_STR) end_at = pos + 11'd1;
        close_pending();
      end
      if (n_toks >= TOKS_MAX) end_at = tok_start;
      emit(KIND_END, end_at, '0, '0, ST_OK, 1'b1);
      clear_line();
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eol);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid    <= 1'b1;
    char_if.ch       <= c;
    char_if.line_end <= eol;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    lex_char(c, eol);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_buf();
    for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_word();
    tok_t want;
    if (expected_toks.size() == 0) begin
      $display("%0t: unexpected word, kind %0d start %0d len %0d", $time, tok_if.kind,
               tok_if.start_pos, tok_if.tok_len);
      errors++;
    end else begin
      want = expected_toks.pop_front();
      cmp_field("kind", want.kind, tok_if.kind);
      cmp_field("start_pos", want.start_pos, tok_if.start_pos);
      cmp_field("tok_len", want.tok_len, tok_if.tok_len);
      cmp_field("int_value", want.int_value, tok_if.int_value);
      cmp_field("token_index", want.token_index, tok_if.token_index);
      cmp_field("status", want.status, tok_if.status);
      cmp_field("last", want.last, tok_if.last);
    end
  endtask

  initial begin
    tok_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && tok_if.valid && tok_if.ready) check_word();
      tok_if.ready <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic void push_digits(int unsigned n);
    repeat (n) line_buf.push_back(8'("0" + $urandom_range(9)));
  endfunction

  function automatic void add_token();
    string       ops;
    logic [7:0]  c;
    int unsigned r;
    ops = "+-^/%~{}()[];:?,#$&|=*!<>";
    r   = $urandom_range(99);
    if (r < 20) begin
      line_buf.push_back(rand_letter());
      repeat ($urandom_range(6)) begin
        case ($urandom_range(2))
          0: line_buf.push_back(rand_letter());
          1: push_digits(1);
          default: line_buf.push_back("_");
        endcase
      end
    end else if (r < 40) begin
      // long runs reach the overflow edge
      push_digits($urandom_range(99) < 15 ? $urandom_range(10, 11) : $urandom_range(1, 4));
    end else if (r < 52) begin
      push_digits($urandom_range(3));
      line_buf.push_back(".");
      push_digits($urandom_range(2));
      if ($urandom_range(99) < 60) begin
        line_buf.push_back($urandom_range(1) ? "e" : "E");
        if ($urandom_range(1)) line_buf.push_back("-");
        if ($urandom_range(99) < 85) push_digits($urandom_range(1, 2));
      end
    end else if (r < 62) begin
      c = $urandom_range(1) ? "'" : "\"";
      line_buf.push_back(c);
      repeat ($urandom_range(5)) line_buf.push_back(8'($urandom_range(32, 126)));
      if ($urandom_range(99) < 80) line_buf.push_back(c);
    end else if (r < 95) begin
      c = ops[$urandom_range(ops.len() - 1)];
      line_buf.push_back(c);
      if ($urandom_range(1)) begin
        if (c == "&" || c == "|" || c == "=" || c == "*") line_buf.push_back(c);
        else if (c == "!" || c == "<" || c == ">") line_buf.push_back("=");
      end
    end else begin
      line_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic logic [7:0] rand_blank();
    int unsigned v;
    v = $urandom_range(8, 13);
    return (v == 8) ? 8'd32 : 8'(v);
  endfunction

  task automatic send_random(input int unsigned n_chars);
    int unsigned sent;
    sent = 0;
    while (sent < n_chars) begin
      line_buf.delete();
      repeat ($urandom_range(1, 8)) begin
        add_token();
        if ($urandom_range(99) < 70) line_buf.push_back(rand_blank());
      end
      send_buf();
      sent += line_buf.size();
    end
  endtask

  task automatic test_directed();
    send_text("x_9<=2147483647 .5E-3 'ab");
    send_text("2147483648+");
    send_text("3e+");
    send_text("4E");
    send_text("_");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  // random lines with neither side idling
  task automatic test_back_to_back();
    calm = 1'b1;
    send_random(BURST_CHARS);
    calm = 1'b0;
  endtask

  task automatic test_random_lines();
    send_random(RAND_CHARS);
  endtask

  initial begin
    #WATCHDOG_NS;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    char_if.valid    = 1'b0;
    char_if.ch       = '0;
    char_if.line_end = 1'b0;
    errors           = 0;
    calm             = 1'b0;
    clear_line();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_back_to_back();
    test_random_lines();

    char_if.valid <= 1'b0;
    while (expected_toks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/el_pkg.sv
src/el_if.sv
src/el_step.sv
src/el_queue.sv
src/expression_lexer_core.sv
tb/tb.sv
